FILE: rtl/core/atsr_pkg.sv
package atsr_pkg;

    // Length limits and counter width
    localparam int CMD_MAX_LEN  = 256;
    localparam int NAME_MAX_LEN = 256;
    localparam int CNT_W        = 9;

    localparam logic [CNT_W-1:0] CMD_LIMIT  = CNT_W'(CMD_MAX_LEN - 1);
    localparam logic [CNT_W-1:0] NAME_LIMIT = CNT_W'(NAME_MAX_LEN - 1);

    // ASCII codes
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_S_UP = 8'h53;
    localparam logic [7:0] CH_L_LO = 8'h6C;
    localparam logic [7:0] CH_O_LO = 8'h6F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Event codes
    typedef enum logic [2:0] {
        EV_OK        = 3'd0,
        EV_ERR       = 3'd1,
        EV_CMD_BYTE  = 3'd2,
        EV_CMD_END   = 3'd3,
        EV_NAME_BYTE = 3'd4,
        EV_NAME_END  = 3'd5,
        EV_OMIT      = 3'd6
    } ev_kind_t;

    // Registered input word handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } stage_t;

    // One parser result
    typedef struct packed {
        logic       valid;
        ev_kind_t   kind;
        logic [7:0] data;
    } event_t;

endpackage

FILE: rtl/core/at_command_slot_report_parser.sv
// Byte-stream parser for "AT" command lines and "Slot<digit>:<name>" reports.
// One received byte is taken per word on the input channel and gives zero or
// one event word (kind plus byte) on the output channel. The block accepts a
// byte every cycle while the output side keeps up. An accepted byte sits in the
// input register; the combinational state machine decision loads the result
// register once it has room, and the receiver takes the event from there. The
// combinational state machine step sets the rate above. Command and name bytes
// stream out as they arrive; command length and name length are limited by
// package constants.
module at_command_slot_report_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output atsr_pkg::ev_kind_t event_kind,
    output logic [7:0]         data_byte
);
    import atsr_pkg::*;

    stage_t stage;
    event_t ev;
    logic   room;
    logic   take;

    // Held byte moves through the parser when the result register has room
    assign take = stage.valid && room;

    atsr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .stage    (stage)
    );

    atsr_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .ev    (ev)
    );

    atsr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .take       (take),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .data_byte  (data_byte)
    );

endmodule

FILE: rtl/core/atsr_in_stage.sv
module atsr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic            take,
    output atsr_pkg::stage_t stage
);
    import atsr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Room when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;

endmodule

FILE: rtl/core/atsr_fsm.sv
module atsr_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  atsr_pkg::stage_t stage,
    input  logic             take,
    output atsr_pkg::event_t ev
);
    import atsr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_A     = 10'b00_0000_0010,
        ST_AT    = 10'b00_0000_0100,
        ST_CMD   = 10'b00_0000_1000,
        ST_S     = 10'b00_0001_0000,
        ST_SL    = 10'b00_0010_0000,
        ST_SLO   = 10'b00_0100_0000,
        ST_SLOT  = 10'b00_1000_0000,
        ST_DIGIT = 10'b01_0000_0000,
        ST_NAME  = 10'b10_0000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cmd_count_reg;
    logic [CNT_W-1:0] cmd_count_next;
    logic [CNT_W-1:0] name_count_reg;
    logic [CNT_W-1:0] name_count_next;
    logic [7:0]       b;
    logic             is_eol;

    assign b      = stage.rx_byte;
    assign is_eol = (b == CH_CR) || (b == CH_LF);

    // Next state and event for the held byte
    always_comb
    begin
        state_next      = state_reg;
        cmd_count_next  = cmd_count_reg;
        name_count_next = name_count_reg;
        ev              = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (b == CH_A_UP || b == CH_A_LO)
                begin
                    state_next = ST_A;
                end
                else if (b == CH_S_UP)
                begin
                    state_next = ST_S;
                end
            end
            ST_A:
            begin
                state_next = (b == CH_T_UP || b == CH_T_LO) ? ST_AT : ST_IDLE;
            end
            ST_AT:
            begin
                if (is_eol)
                begin
                    state_next = ST_IDLE;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_OK;
                end
                else if (b == CH_SP)
                begin
                    cmd_count_next = '0;
                    state_next     = ST_CMD;
                end
                else
                begin
                    state_next = ST_IDLE;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_ERR;
                end
            end
            ST_CMD:
            begin
                // Line end, or the byte that hits the limit, closes the command
                if (is_eol || cmd_count_reg >= CMD_LIMIT)
                begin
                    state_next = ST_IDLE;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_CMD_END;
                end
                else
                begin
                    cmd_count_next = cmd_count_reg + CNT_W'(1);
                    ev.valid       = 1'b1;
                    ev.kind        = EV_CMD_BYTE;
                    ev.data        = b;
                end
            end
            ST_S:
            begin
                state_next = (b == CH_L_LO) ? ST_SL : ST_IDLE;
            end
            ST_SL:
            begin
                state_next = (b == CH_O_LO) ? ST_SLO : ST_IDLE;
            end
            ST_SLO:
            begin
                state_next = (b == CH_T_LO) ? ST_SLOT : ST_IDLE;
            end
            ST_SLOT:
            begin
                if (b == CH_COLON)
                begin
                    state_next = ST_IDLE;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_OMIT;
                end
                else if (b >= CH_0 && b <= CH_9)
                begin
                    name_count_next = '0;
                    state_next      = ST_DIGIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIGIT:
            begin
                state_next = (b == CH_COLON) ? ST_NAME : ST_IDLE;
            end
            ST_NAME:
            begin
                if (b == CH_NUL || is_eol)
                begin
                    state_next = ST_IDLE;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_NAME_END;
                end
                else if (name_count_reg < NAME_LIMIT)
                begin
                    // bytes past the limit are dropped silently
                    name_count_next = name_count_reg + CNT_W'(1);
                    ev.valid        = 1'b1;
                    ev.kind         = EV_NAME_BYTE;
                    ev.data         = b;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ev.valid   = 1'b1;
                ev.kind    = EV_ERR;
            end
        endcase
        // nothing to report without a held byte
        if (!stage.valid)
        begin
            ev.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_count_reg  <= '0;
            name_count_reg <= '0;
        end
        else if (take)
        begin
            state_reg      <= state_next;
            cmd_count_reg  <= cmd_count_next;
            name_count_reg <= name_count_next;
        end
    end

`ifndef ASSERT_OFF
    a_cmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_count_reg <= CMD_LIMIT)
        else $error("command count past limit");

    a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
        name_count_reg <= NAME_LIMIT)
        else $error("name count past limit");

    a_cmd_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ev.valid && ev.kind == EV_CMD_BYTE)
        |=> (cmd_count_reg == $past(cmd_count_reg) + CNT_W'(1)))
        else $error("command byte without count step");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> stage.valid)
        else $error("parser advanced without a byte");
`endif

endmodule

FILE: rtl/core/atsr_out_stage.sv
module atsr_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  atsr_pkg::event_t   ev,
    input  logic               take,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output atsr_pkg::ev_kind_t event_kind,
    output logic [7:0]         data_byte
);
    import atsr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       load;
    ev_kind_t   kind_reg;
    logic [7:0] data_reg;

    // Free when empty or being drained this cycle
    assign room = !valid_reg || out_ready;
    assign load = take && ev.valid;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result word, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= ev.kind;
            data_reg <= ev.data;
        end
    end

    assign out_valid  = valid_reg;
    assign event_kind = kind_reg;
    assign data_byte  = data_reg;

endmodule

FILE: bench/at_command_slot_report_parser_test.sv
module at_command_slot_report_parser_test;

    import atsr_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 100;
    localparam int MAX_GAP        = 18;
    localparam int RANDOM_WORDS   = 1000;

    // Parser states as seen by the predictor
    typedef enum int {
        P_IDLE, P_A, P_AT, P_CMD, P_S, P_SL, P_SLO, P_SLOT, P_DIGIT, P_NAME
    } parse_state_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] data;
    } parse_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    ev_kind_t event_kind;
    logic [7:0] data_byte;

    at_command_slot_report_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .data_byte  (data_byte)
    );

    // Stimulus and prediction stores
    logic [7:0]   rx_backlog[$];
    parse_event_t predicted_events[$];
    int words_queued = 0;
    int words_accepted = 0;
    int line_words = 0;
    int errors = 0;

    // Predictor state
    parse_state_t parse_st = P_IDLE;
    logic [CNT_W-1:0] cmd_len = '0;
    logic [CNT_W-1:0] name_len = '0;

    // Handshakes seen at the last rising edge
    logic in_hs = 1'b0;
    logic out_hs = 1'b0;

    // Sender and receiver pacing
    int  gap_left = 0;
    bit  in_calm = 1'b0;
    int  hold_left = 0;
    int  draw_wait = 0;
    bit  out_calm = 1'b0;
    bit  long_hold_done = 1'b0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    parse_event_t want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_event(input ev_kind_t kind, input logic [7:0] data);
        parse_event_t ev;
        begin
            ev.kind = kind;
            ev.data = data;
            predicted_events.push_back(ev);
        end
    endtask

    // One parser step per accepted word
    task automatic parse_byte(input logic [7:0] b);
        begin
            case (parse_st)
                P_IDLE:
                begin
                    if (b == CH_A_UP || b == CH_A_LO)
                        parse_st = P_A;
                    else if (b == CH_S_UP)
                        parse_st = P_S;
                end
                P_A:
                    parse_st = (b == CH_T_UP || b == CH_T_LO) ? P_AT : P_IDLE;
                P_AT:
                begin
                    if (b == CH_CR || b == CH_LF)
                    begin
                        parse_st = P_IDLE;
                        push_event(EV_OK, 8'h00);
                    end
                    else if (b == CH_SP)
                    begin
                        cmd_len = '0;
                        parse_st = P_CMD;
                    end
                    else
                    begin
                        parse_st = P_IDLE;
                        push_event(EV_ERR, 8'h00);
                    end
                end
                P_CMD:
                begin
                    // limit hit: this byte is swallowed and ends the command
                    if (b == CH_CR || b == CH_LF || cmd_len >= CMD_LIMIT)
                    begin
                        parse_st = P_IDLE;
                        push_event(EV_CMD_END, 8'h00);
                    end
                    else
                    begin
                        cmd_len = cmd_len + CNT_W'(1);
                        push_event(EV_CMD_BYTE, b);
                    end
                end
                P_S:
                    parse_st = (b == CH_L_LO) ? P_SL : P_IDLE;
                P_SL:
                    parse_st = (b == CH_O_LO) ? P_SLO : P_IDLE;
                P_SLO:
                    parse_st = (b == CH_T_LO) ? P_SLOT : P_IDLE;
                P_SLOT:
                begin
                    if (b == CH_COLON)
                    begin
                        parse_st = P_IDLE;
                        push_event(EV_OMIT, 8'h00);
                    end
                    else if (b >= CH_0 && b <= CH_9)
                    begin
                        name_len = '0;
                        parse_st = P_DIGIT;
                    end
                    else
                        parse_st = P_IDLE;
                end
                P_DIGIT:
                    parse_st = (b == CH_COLON) ? P_NAME : P_IDLE;
                P_NAME:
                begin
                    if (b == CH_NUL || b == CH_CR || b == CH_LF)
                    begin
                        parse_st = P_IDLE;
                        push_event(EV_NAME_END, 8'h00);
                    end
                    else if (name_len < NAME_LIMIT)
                    begin
                        name_len = name_len + CNT_W'(1);
                        push_event(EV_NAME_BYTE, b);
                    end
                    // past the limit: dropped silently
                end
                default:
                begin
                    parse_st = P_IDLE;
                    push_event(EV_ERR, 8'h00);
                end
            endcase
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        begin
            rx_backlog.push_back(b);
            words_queued++;
        end
    endtask

    task automatic queue_text(input string s);
        int i;
        begin
            for (i = 0; i < s.len(); i++)
                queue_byte(s[i]);
        end
    endtask

    // Random byte that does not end a command or a name
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_CR || b == CH_LF || b == CH_NUL)
                b = b ^ 8'h80;
            return b;
        end
    endfunction

    // One random line: AT reply or command, slot report, or noise
    task automatic queue_random_line();
        logic [7:0] line[$];
        int sel;
        int kind;
        int n;
        int i;
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                line.push_back($urandom_range(0, 1) ? CH_A_UP : CH_A_LO);
                line.push_back($urandom_range(0, 1) ? CH_T_UP : CH_T_LO);
                sel = $urandom_range(0, 5);
                if (sel == 0)
                    line.push_back(CH_CR);
                else if (sel == 1)
                    line.push_back(CH_LF);
                else if (sel == 2)
                    line.push_back(8'($urandom_range(0, 255)));
                else
                begin
                    line.push_back(CH_SP);
                    n = $urandom_range(0, 12);
                    for (i = 0; i < n; i++)
                        line.push_back(8'($urandom_range(0, 255)));
                    line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
            end
            else if (kind < 8)
            begin
                line.push_back(CH_S_UP);
                line.push_back(CH_L_LO);
                line.push_back(CH_O_LO);
                line.push_back(CH_T_LO);
                sel = $urandom_range(0, 5);
                if (sel == 0)
                    line.push_back(CH_COLON);
                else if (sel == 1)
                    line.push_back(8'($urandom_range(0, 255)));
                else
                begin
                    line.push_back(8'($urandom_range(CH_0, CH_9)));
                    line.push_back(CH_COLON);
                    n = $urandom_range(0, 12);
                    for (i = 0; i < n; i++)
                        line.push_back(8'($urandom_range(0, 255)));
                    sel = $urandom_range(0, 2);
                    line.push_back(sel == 0 ? CH_NUL : (sel == 1 ? CH_CR : CH_LF));
                end
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    line.push_back(8'($urandom_range(0, 255)));
            end
            // break some lines with a stray byte
            if (kind < 8 && $urandom_range(0, 7) == 0)
                line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
            foreach (line[i])
                queue_byte(line[i]);
            if (kind < 8)
                line_words += line.size();
        end
    endtask

    task automatic drain();
        begin
            while (words_accepted != words_queued || predicted_events.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Sender: one word per item, random gap drawn after each load
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_hs))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rx_backlog.size() > 0)
            begin
                rx_byte <= rx_backlog.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    in_calm = !in_calm;
                gap_left = in_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random hold-off after each word, one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hs)
                results_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_hs && !long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (out_hs)
            begin
                if ($urandom_range(0, 99) == 0)
                    out_calm = !out_calm;
                draw_wait = out_calm ? 0 : $urandom_range(0, MAX_GAP);
                if (draw_wait == 0)
                    out_ready <= 1'b1;
                else
                begin
                    hold_left = draw_wait - 1;
                    out_ready <= 1'b0;
                end
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: check results, then feed accepted words to the predictor
    always @(posedge clk)
    begin
        in_hs <= rst_n && in_valid && in_ready;
        out_hs <= rst_n && out_valid && out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_events.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got kind %0d data %02h",
                             $time, event_kind, data_byte);
                    errors++;
                end
                else
                begin
                    want = predicted_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        $display("%0t: event_kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, event_kind);
                        errors++;
                    end
                    if (data_byte !== want.data)
                    begin
                        $display("%0t: data_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, data_byte);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                parse_byte(rx_byte);
                words_accepted++;
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: ok on CR and LF, error, command with byte extremes,
        // omitted report, name with a high byte
        queue_text("AT\r");
        queue_text("at\n");
        queue_text("aTQ");
        queue_text("At ");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_CR);
        queue_text("Slot:");
        queue_text("Slot9:");
        queue_byte(8'hFF);
        queue_byte(CH_LF);
        drain();

        // Command past the length limit, name past the length limit
        queue_text("AT ");
        for (i = 0; i < 258; i++)
            queue_byte(body_byte());
        queue_byte(CH_CR);
        queue_text("Slot3:");
        for (i = 0; i < 262; i++)
            queue_byte(body_byte());
        queue_byte(CH_NUL);
        while (line_words < RANDOM_WORDS / 2)
            queue_random_line();
        drain();

        // Sender pauses above until all results are in, then the rest
        while (line_words < RANDOM_WORDS)
            queue_random_line();
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: at_command_slot_report_parser.f
rtl/core/atsr_pkg.sv
rtl/core/atsr_in_stage.sv
rtl/core/atsr_fsm.sv
rtl/core/atsr_out_stage.sv
rtl/core/at_command_slot_report_parser.sv
bench/at_command_slot_report_parser_test.sv
